@@ rtl/isqrt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isqrt_pkg: shared types and constants for the integer square root
// Widths of the radicand, root and partial remainder, and the word that
// travels from cell to cell down the root chain.
// ----------------------------------------------------------------------------
package isqrt_pkg;

    localparam int RADICAND_W = 32;
    localparam int ROOT_W     = 16;
    localparam int REM_W      = 18;
    localparam int REM_SH_W   = REM_W + 2;
    localparam int KEEP_BITS  = 8;
    localparam int CNT_W      = 4;
    localparam int NUM_CELLS  = ROOT_W;

    localparam logic [CNT_W-1:0] CNT_KEEP = CNT_W'(KEEP_BITS);

    typedef enum logic
    {
        REQ_EXACT  = 1'b0,
        REQ_APPROX = 1'b1
    } req_type_t;

    typedef struct packed
    {
        logic [RADICAND_W-1:0] x;
        logic [REM_W-1:0]      rem;
        logic [ROOT_W-1:0]     root;
        req_type_t             req;
        logic [CNT_W-1:0]      cnt;
    } isqrt_word_t;

endpackage
`default_nettype wire

@@ rtl/isqrt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isqrt_cell: one root bit of the square root chain
// Brings down the next two radicand bits, tries the next root bit against
// the partial remainder and hands the updated word to the next cell.
// ----------------------------------------------------------------------------
module isqrt_cell
    import isqrt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire logic        prev_valid,
    input  wire isqrt_word_t prev_word,
    output logic             valid,
    output isqrt_word_t      word
);

    logic        valid_reg;
    isqrt_word_t word_reg;
    isqrt_word_t word_next;

    logic [REM_SH_W-1:0] rem_sh;
    logic [REM_SH_W-1:0] trial;
    logic [REM_SH_W-1:0] rem_diff;
    logic                keep;
    logic                take;
    logic                started;

    always_comb
    begin
        rem_sh   = {prev_word.rem, prev_word.x[RADICAND_W-1 -: 2]};
        trial    = {2'b00, prev_word.root, 2'b01};
        rem_diff = rem_sh - trial;
        // past the top eight significant root bits an approximate request drops the rest
        keep     = !(prev_word.req == REQ_APPROX && prev_word.cnt == CNT_KEEP);
        take     = keep && (rem_sh >= trial);
        started  = (prev_word.cnt != '0) || take;

        word_next      = prev_word;
        word_next.x    = {prev_word.x[RADICAND_W-3:0], 2'b00};
        word_next.rem  = take ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        word_next.root = {prev_word.root[ROOT_W-2:0], take};
        if (started && prev_word.cnt != CNT_KEEP)
        begin
            word_next.cnt = prev_word.cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            word_reg <= word_next;
        end
    end

    assign valid = valid_reg;
    assign word  = word_reg;

endmodule
`default_nettype wire

@@ rtl/integer_square_root_32.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_square_root_32: 32-bit unsigned integer square root
// A chain of sixteen cells, one per root bit, followed by an output
// register. A new word enters every cycle while the output side keeps
// up; each root passes through the sixteen cell registers and then the
// output register. The whole chain holds while out_stall keeps a
// finished root waiting. req_type 0 gives floor(sqrt(radicand));
// req_type 1 keeps only the top eight significant bits of that root and
// clears the lower ones.
// ----------------------------------------------------------------------------
module integer_square_root_32
    import isqrt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [RADICAND_W-1:0] radicand,
    input  wire logic                  req_type,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [ROOT_W-1:0]          root
);

    logic        advance;
    logic        chain_valid [NUM_CELLS+1];
    isqrt_word_t chain_word  [NUM_CELLS+1];

    logic              out_valid_reg;
    logic [ROOT_W-1:0] root_reg;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    assign chain_valid[0] = in_valid;
    assign chain_word[0]  = '{x:    radicand,
                              rem:  REM_W'(0),
                              root: ROOT_W'(0),
                              req:  req_type_t'(req_type),
                              cnt:  CNT_W'(0)};

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        isqrt_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .prev_valid (chain_valid[i]),
            .prev_word  (chain_word[i]),
            .valid      (chain_valid[i+1]),
            .word       (chain_word[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            root_reg <= chain_word[NUM_CELLS].root;
        end
    end

    assign out_valid = out_valid_reg;
    assign root      = root_reg;

endmodule
`default_nettype wire
